// ===== hw/rtl/pgtd_pkg.sv =====
// Package for the trial-division prime generator.
// Field widths, reset constants and the divider request/response types.
// No dependencies.
package pgtd_pkg;

  localparam int VAL_W = 14;
  localparam int CAND_W = 15;
  localparam int OP_W = 32;
  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int DIV_CNT_W = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] LIMIT_RESET = VAL_W'(1000);
  localparam logic [VAL_W-1:0] FIRST_PRIME = VAL_W'(2);
  localparam logic [VAL_W-1:0] SECOND_PRIME = VAL_W'(3);
  localparam logic [CAND_W-1:0] FIRST_CAND = CAND_W'(5);
  localparam logic [CAND_W-1:0] CAND_STEP = CAND_W'(2);

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_rsp_t;

endpackage

// ===== hw/rtl/pgtd_table.sv =====
// Prime table: one write port, one read port, registered read data.
// Depends on pgtd_pkg.
module pgtd_table
  import pgtd_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pgtd_div.sv =====
// Bit-serial remainder unit, one quotient bit per cycle.
// Depends on pgtd_pkg.
module pgtd_div
  import pgtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W:0]       rem_r, rem_nxt;
  logic [VAL_W-1:0]     dvd_r, dvd_nxt;
  logic [VAL_W-1:0]     dsr_r, dsr_nxt;
  logic [VAL_W:0]       shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r[VAL_W-1:0], dvd_r[VAL_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(VAL_W - 1);
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = (shifted >= {1'b0, dsr_r}) ? shifted - {1'b0, dsr_r} : shifted;
      dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.rem_zero = (rem_r == '0);

endmodule

// ===== hw/rtl/pgtd_ctrl.sv =====
// Sequencer: candidate walk, trial loop over the prime table, counters and
// output register. Depends on pgtd_pkg; drives pgtd_table and pgtd_div.
module pgtd_ctrl
  import pgtd_pkg::*;
#(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_prime_value,
  output logic             out_prime_valid,
  output logic [OP_W-1:0]  out_operation_count,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [VAL_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [VAL_W-1:0] mem_rdata,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_CAND  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_MOD   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [VAL_W-1:0]  limit_r;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [CAND_W-1:0] cand_r, cand_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic              exh_r, exh_nxt;
  logic [VAL_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_pvalid_r, out_pvalid_nxt;
  logic [OP_W-1:0]   out_op_r, out_op_nxt;
  logic [OP_W-1:0]   op_inc;
  logic [2*VAL_W-1:0] p_sq;

  assign op_inc = (op_r == '1) ? op_r : op_r + 1'b1;
  assign p_sq   = {{VAL_W{1'b0}}, mem_rdata} * {{VAL_W{1'b0}}, mem_rdata};

  always_comb begin
    state_nxt      = state_r;
    fc_nxt         = fc_r;
    cand_nxt       = cand_r;
    op_nxt         = op_r;
    exh_nxt        = exh_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    res_value_nxt  = res_value_r;
    res_valid_nxt  = res_valid_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_pvalid_nxt = out_pvalid_r;
    out_op_nxt     = out_op_r;
    mem_we         = 1'b0;
    mem_waddr      = fc_r[IDX_W-1:0];
    mem_wdata      = n_r;
    mem_re         = 1'b0;
    mem_raddr      = idx_r[IDX_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = n_r;
    div_req.divisor  = mem_rdata;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_restart) begin
            fc_nxt   = '0;
            cand_nxt = FIRST_CAND;
            op_nxt   = '0;
            exh_nxt  = 1'b0;
          end
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        res_value_nxt = '0;
        res_valid_nxt = 1'b0;
        state_nxt     = ST_DONE;
        if (exh_r) begin
          state_nxt = ST_DONE;
        end else if (fc_r >= CNT_W'(DEPTH)) begin
          exh_nxt = 1'b1;
        end else if (fc_r == '0 || fc_r == CNT_W'(1)) begin
          mem_we        = 1'b1;
          mem_wdata     = (fc_r == '0) ? FIRST_PRIME : SECOND_PRIME;
          fc_nxt        = fc_r + 1'b1;
          res_value_nxt = mem_wdata;
          res_valid_nxt = 1'b1;
        end else begin
          state_nxt = ST_CAND;
        end
      end
      ST_CAND: begin
        if (cand_r <= {1'b0, limit_r}) begin
          n_nxt     = cand_r[VAL_W-1:0];
          cand_nxt  = cand_r + CAND_STEP;
          idx_nxt   = CNT_W'(1);
          state_nxt = ST_CHECK;
        end else begin
          exh_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_CHECK: begin
        op_nxt = op_inc;
        if (idx_r >= fc_r) begin
          mem_we        = 1'b1;
          fc_nxt        = fc_r + 1'b1;
          res_value_nxt = n_r;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (p_sq > {{VAL_W{1'b0}}, n_r}) begin
          mem_we        = 1'b1;
          fc_nxt        = fc_r + 1'b1;
          res_value_nxt = n_r;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          op_nxt = op_inc;
          if (mem_rdata == '0) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_CHECK;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) begin
            state_nxt = ST_CAND;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_pvalid_nxt = res_valid_r;
          out_op_nxt     = op_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      fc_r        <= '0;
      cand_r      <= FIRST_CAND;
      op_r        <= '0;
      exh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      cand_r      <= cand_nxt;
      op_r        <= op_nxt;
      exh_r       <= exh_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    res_value_r  <= res_value_nxt;
    res_valid_r  <= res_valid_nxt;
    out_value_r  <= out_value_nxt;
    out_pvalid_r <= out_pvalid_nxt;
    out_op_r     <= out_op_nxt;
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_prime_value     = out_value_r;
  assign out_prime_valid     = out_pvalid_r;
  assign out_operation_count = out_op_r;

endmodule

// ===== hw/rtl/prime_generator_trial_division_top.sv =====
// Top level of the trial-division prime generator.
// Depends on pgtd_pkg, pgtd_table, pgtd_div and pgtd_ctrl.
//
// Each input transaction (in_valid/in_ready, field in_restart) yields exactly
// one output transaction (out_valid/out_ready) carrying the next prime, a
// prime-valid flag and the saturating operation count. in_restart=1 clears
// the sequence first, so that transaction returns 2.
// cfg_wr_en/cfg_wr_data write upper_limit (reset value 1000).
// From acceptance to out_valid, the primes 2 and 3 and an exhausted sequence
// take the short path; otherwise the time grows with each candidate compared
// with the limit, each divisor read and each remainder computed; the bit-serial
// remainder unit dominates. One transaction is in work at a time; in_ready is
// high only when idle. A finished result sits in the output register; a new
// request is taken while it waits, and its own result stalls until out_ready
// drains the register. Synchronous reset (rst_n low) clears the sequence
// state and the output valid flag and restores the limit; the prime table
// needs no clearing, since entries are only read after they are written.
module prime_generator_trial_division_top
  import pgtd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_prime_value,
  output logic             out_prime_valid,
  output logic [OP_W-1:0]  out_operation_count,
  input  logic             cfg_wr_en,
  input  logic [VAL_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  pgtd_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_prime_value     (out_prime_value),
    .out_prime_valid     (out_prime_valid),
    .out_operation_count (out_operation_count),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_re              (mem_re),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata),
    .div_req             (div_req),
    .div_rsp             (div_rsp)
  );

  pgtd_table #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pgtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== hw/rtl/pgtd_checker.sv =====
// Port-level checks for the prime generator, bound to the top level.
// Depends on pgtd_pkg and prime_generator_trial_division_top.
module pgtd_checker
  import pgtd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_prime_value,
  input logic             out_prime_valid,
  input logic [OP_W-1:0]  out_operation_count
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prime_value)
      && $stable(out_prime_valid) && $stable(out_operation_count))
    else $error("stalled transaction changed");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_prime_valid |-> out_prime_value == '0)
    else $error("invalid result carries a value");

  a_valid_ge_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prime_valid |-> out_prime_value >= FIRST_PRIME)
    else $error("prime below two");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while first in work");

endmodule

bind prime_generator_trial_division_top pgtd_checker u_pgtd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_prime_value     (out_prime_value),
  .out_prime_valid     (out_prime_valid),
  .out_operation_count (out_operation_count)
);

// ===== tb/tb.sv =====
// Self-checking testbench for prime_generator_trial_division_top: sends next-prime and
// restart transactions, predicts each result and checks it field by field.
// Depends on pgtd_pkg and the prime generator RTL.
`timescale 1ns / 1ps

module tb;
  import pgtd_pkg::*;

  localparam int PERIOD = 20;
  localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
  localparam int HOLD_CYCLES = 2000;
  localparam int END_CYCLES = 50;
  localparam int LIMIT_MIN = 5;
  localparam int LIMIT_MAX = 16383;
  localparam int RUN_LIMIT = 1500;
  localparam int RUN_ITEMS = 244;
  localparam longint TIMEOUT_NS = 64'd400_000_000;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             valid;
    logic [OP_W-1:0]  ops;
  } prime_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_restart = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] out_prime_value;
  logic             out_prime_valid;
  logic [OP_W-1:0]  out_operation_count;
  logic             cfg_wr_en = 1'b0;
  logic [VAL_W-1:0] cfg_wr_data = '0;

  logic [VAL_W-1:0] prime_tbl [TBL_DEPTH];
  int               n_found;
  int               next_cand;
  logic [OP_W-1:0]  op_total;
  bit               seq_done;
  int               limit_val;

  prime_result_t expected_primes [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stalls_asked = 0;
  int stalls_done = 0;
  int stall_left = 0;

  prime_generator_trial_division_top #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_prime_value    (out_prime_value),
    .out_prime_valid    (out_prime_valid),
    .out_operation_count(out_operation_count),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic void clear_sequence();
    n_found = 0;
    next_cand = FIRST_CAND;
    op_total = '0;
    seq_done = 1'b0;
  endfunction

  function automatic void count_op();
    if (op_total != '1) op_total = op_total + 1'b1;
  endfunction

  function automatic bit no_divisor(int n);
    int p;
    for (int i = 1; i <= n_found; i++) begin
      count_op();
      if (i >= n_found) return 1'b1;
      p = prime_tbl[i];
      if (p * p > n) return 1'b1;
      count_op();
      if (p != 0 && n % p == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void store_prime(int v);
    prime_tbl[n_found] = VAL_W'(v);
    n_found++;
  endfunction

  function automatic prime_result_t next_prime(logic restart);
    prime_result_t r;
    int n;
    r = '0;
    if (restart) clear_sequence();
    if (!seq_done) begin
      if (n_found >= TBL_DEPTH) begin
        seq_done = 1'b1;
      end else if (n_found == 0) begin
        store_prime(FIRST_PRIME);
        r.value = FIRST_PRIME;
        r.valid = 1'b1;
      end else if (n_found == 1) begin
        store_prime(SECOND_PRIME);
        r.value = SECOND_PRIME;
        r.valid = 1'b1;
      end else begin
        while (next_cand <= limit_val && !r.valid) begin
          n = next_cand;
          next_cand += CAND_STEP;
          if (no_divisor(n)) begin
            store_prime(n);
            r.value = VAL_W'(n);
            r.valid = 1'b1;
          end
        end
        if (!r.valid) seq_done = 1'b1;
      end
    end
    r.ops = op_total;
    return r;
  endfunction

  task automatic send_request(input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_primes.push_back(next_prime(restart));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_primes.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input int lim);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= VAL_W'(lim);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_val = lim;
  endtask

  task automatic test_first_primes();
    send_request(1'b0);
    send_request(1'b0);
    wait_results();
    write_limit(LIMIT_MIN);
    repeat (3) send_request(1'b0);
    wait_results();
  endtask

  task automatic test_exhausted_hold();
    write_limit(LIMIT_MAX);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_results();
  endtask

  task automatic test_limit_change();
    send_request(1'b0);
    send_request(1'b0);
    wait_results();
    write_limit(10);
    send_request(1'b0);
    wait_results();
    write_limit(LIMIT_MAX);
    send_request(1'b0);
    wait_results();
  endtask

  task automatic test_output_hold();
    stalls_asked <= stalls_asked + 1;
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    wait_results();
  endtask

  task automatic test_random_sequences(input int n_items);
    int sent;
    int len;
    int lim;
    bit fresh;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: lim = LIMIT_MIN;
        1: lim = LIMIT_MAX;
        2: lim = LIMIT_RESET;
        3, 4: lim = $urandom_range(200, LIMIT_MIN);
        default: lim = $urandom_range(LIMIT_MAX, LIMIT_MIN);
      endcase
      write_limit(lim);
      fresh = $urandom_range(1);
      len = $urandom_range(150, 10);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_request(($urandom_range(99) == 0) || (k == 0 && fresh));
        sent++;
      end
      wait_results();
    end
  endtask

  task automatic test_run_to_limit();
    write_limit(RUN_LIMIT);
    send_request(1'b1);
    repeat (RUN_ITEMS) send_request(1'b0);
    send_request(1'b1);
    wait_results();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_done != stalls_asked) begin
      out_ready <= 1'b0;
      stall_left <= HOLD_CYCLES;
      stalls_done <= stalls_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    prime_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_primes.size() == 0) begin
        $display("%0t: transaction with none expected, got value %0d valid %0b count %0d",
                 $time, out_prime_value, out_prime_valid, out_operation_count);
        errors++;
      end else begin
        want = expected_primes.pop_front();
        if (out_prime_value !== want.value) begin
          $display("%0t: prime_value expected %0d, got %0d",
                   $time, want.value, out_prime_value);
          errors++;
        end
        if (out_prime_valid !== want.valid) begin
          $display("%0t: prime_valid expected %0b, got %0b",
                   $time, want.valid, out_prime_valid);
          errors++;
        end
        if (out_operation_count !== want.ops) begin
          $display("%0t: operation_count expected %0d, got %0d",
                   $time, want.ops, out_operation_count);
          errors++;
        end
      end
    end
  end

  initial begin
    clear_sequence();
    limit_val = LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 8;
    recv_idle_pct = 46;
    test_first_primes();
    test_exhausted_hold();
    test_limit_change();
    test_output_hold();
    test_random_sequences(180);
    send_idle_pct = 46;
    recv_idle_pct = 8;
    test_random_sequences(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sequences(180);
    test_run_to_limit();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && expected_primes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pgtd_pkg.sv
hw/rtl/pgtd_table.sv
hw/rtl/pgtd_div.sv
hw/rtl/pgtd_ctrl.sv
hw/rtl/prime_generator_trial_division_top.sv
hw/rtl/pgtd_checker.sv
tb/tb.sv
